[rtl/core/qau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// shared constants and operation codes of the quaternion arithmetic unit
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int unsigned CompWidth = 16;
  localparam int unsigned FracBits  = 14;
  localparam int unsigned OpWidth   = 4;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD        = OpWidth'(0),
    OP_SUB        = OpWidth'(1),
    OP_MUL        = OpWidth'(2),
    OP_NEG        = OpWidth'(3),
    OP_CONJ       = OpWidth'(4),
    OP_DOT        = OpWidth'(5),
    OP_SCALE      = OpWidth'(6),
    OP_ADD_SCALAR = OpWidth'(7),
    OP_SCALAR_SUB = OpWidth'(8)
  } op_e;

endpackage

[rtl/core/qau_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_mul
// first stage: all sixteen component products, operands carried along
// ----------------------------------------------------------------------------
module qau_mul import qau_pkg::*; #(
  parameter int unsigned CW = CompWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  op_e                  in_op_i,
  input  logic signed [CW-1:0] in_a_i [4],
  input  logic signed [CW-1:0] in_b_i [4],
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output op_e                  out_op_o,
  output logic signed [CW-1:0] out_a_o [4],
  output logic signed [CW-1:0] out_b_o [4],
  output logic signed [2*CW-1:0] out_prod_o [4][4]
);

  logic                   valid_q;
  op_e                    op_q;
  logic signed [CW-1:0]   a_q [4];
  logic signed [CW-1:0]   b_q [4];
  logic signed [2*CW-1:0] prod_d [4][4];
  logic signed [2*CW-1:0] prod_q [4][4];
  logic                   load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // prod[m][n] = a[m] * b[n]
  always_comb begin
    for (int m = 0; m < 4; m++) begin
      for (int n = 0; n < 4; n++) begin
        prod_d[m][n] = (2*CW)'(in_a_i[m]) * (2*CW)'(in_b_i[n]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= in_op_i;
      a_q    <= in_a_i;
      b_q    <= in_b_i;
      prod_q <= prod_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_op_o    = op_q;
  assign out_a_o     = a_q;
  assign out_b_o     = b_q;
  assign out_prod_o  = prod_q;

endmodule

[rtl/core/qau_sum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_sum
// second stage: per-operation combination of products or operands
// ----------------------------------------------------------------------------
module qau_sum import qau_pkg::*; #(
  parameter int unsigned CW   = CompWidth,
  parameter int unsigned AccW = 2 * CW + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  op_e                    in_op_i,
  input  logic signed [CW-1:0]   in_a_i [4],
  input  logic signed [CW-1:0]   in_b_i [4],
  input  logic signed [2*CW-1:0] in_prod_i [4][4],
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_scaled_o,
  output logic signed [AccW-1:0] out_acc_o [4]
);

  logic                   valid_q;
  logic                   scaled_d, scaled_q;
  logic signed [AccW-1:0] acc_d [4];
  logic signed [AccW-1:0] acc_q [4];
  logic signed [AccW-1:0] ax [4];
  logic signed [AccW-1:0] bx [4];
  logic signed [AccW-1:0] px [4][4];
  logic                   load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      ax[m] = AccW'(in_a_i[m]);
      bx[m] = AccW'(in_b_i[m]);
      for (int n = 0; n < 4; n++) begin
        px[m][n] = AccW'(in_prod_i[m][n]);
      end
    end
  end

  // scaled: value carries fraction bits and gets the floor shift downstream
  always_comb begin
    scaled_d = 1'b0;
    for (int n = 0; n < 4; n++) begin
      acc_d[n] = '0;
    end
    case (in_op_i)
      OP_ADD: begin
        for (int n = 0; n < 4; n++) acc_d[n] = ax[n] + bx[n];
      end
      OP_SUB: begin
        for (int n = 0; n < 4; n++) acc_d[n] = ax[n] - bx[n];
      end
      OP_MUL: begin
        scaled_d = 1'b1;
        acc_d[0] = px[0][0] - px[1][1] - px[2][2] - px[3][3];
        acc_d[1] = px[0][1] + px[1][0] + px[2][3] - px[3][2];
        acc_d[2] = px[0][2] - px[1][3] + px[2][0] + px[3][1];
        acc_d[3] = px[0][3] + px[1][2] - px[2][1] + px[3][0];
      end
      OP_NEG: begin
        for (int n = 0; n < 4; n++) acc_d[n] = -ax[n];
      end
      OP_CONJ: begin
        acc_d[0] = ax[0];
        for (int n = 1; n < 4; n++) acc_d[n] = -ax[n];
      end
      OP_DOT: begin
        scaled_d = 1'b1;
        acc_d[0] = px[0][0] + px[1][1] + px[2][2] + px[3][3];
      end
      OP_SCALE: begin
        scaled_d = 1'b1;
        for (int n = 0; n < 4; n++) acc_d[n] = px[n][0];
      end
      OP_ADD_SCALAR: begin
        acc_d[0] = ax[0] + bx[0];
        for (int n = 1; n < 4; n++) acc_d[n] = ax[n];
      end
      OP_SCALAR_SUB: begin
        acc_d[0] = bx[0] - ax[0];
        for (int n = 1; n < 4; n++) acc_d[n] = -ax[n];
      end
      default: begin
        scaled_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      scaled_q <= scaled_d;
      acc_q    <= acc_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_scaled_o = scaled_q;
  assign out_acc_o    = acc_q;

endmodule

[rtl/core/qau_sat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_sat
// third stage: floor shift, saturation, overflow flag and output register
// ----------------------------------------------------------------------------
module qau_sat import qau_pkg::*; #(
  parameter int unsigned CW   = CompWidth,
  parameter int unsigned FB   = FracBits,
  parameter int unsigned AccW = 2 * CW + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_scaled_i,
  input  logic signed [AccW-1:0] in_acc_i [4],
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [CW-1:0]   out_res_o [4],
  output logic                   out_ovf_o
);

  localparam logic signed [AccW-1:0] SatMax =
    {{(AccW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatMin = ~SatMax;

  logic                   valid_q;
  logic signed [AccW-1:0] shifted [4];
  logic signed [CW-1:0]   res_d [4];
  logic signed [CW-1:0]   res_q [4];
  logic                   ovf_d, ovf_q;
  logic                   load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    ovf_d = 1'b0;
    for (int n = 0; n < 4; n++) begin
      shifted[n] = in_scaled_i ? (in_acc_i[n] >>> FB) : in_acc_i[n];
      if (shifted[n] > SatMax) begin
        res_d[n] = SatMax[CW-1:0];
        ovf_d    = 1'b1;
      end else if (shifted[n] < SatMin) begin
        res_d[n] = SatMin[CW-1:0];
        ovf_d    = 1'b1;
      end else begin
        res_d[n] = shifted[n][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign out_ovf_o   = ovf_q;

endmodule

[rtl/core/quaternion_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// fixed-point quaternion alu: add, sub, hamilton product, negate, conjugate,
// dot, scale, add scalar, scalar minus, with saturation and overflow flag
//
//  channel   dir  signals                 contents
//  --------  ---  ----------------------  -----------------------------------
//  request   in   s_axis_t{valid,ready}   tuser = req_type
//                 s_axis_tdata/tuser      tdata = a_r a_i a_j a_k b_r b_i b_j b_k
//  result    out  m_axis_t{valid,ready}   tdata = res_r res_i res_j res_k
//                 m_axis_tuser            tuser = overflow
//
// one request per clock sustained while the result side is ready; three register stages
// (product stage, combine stage, shift/saturate stage with output register), and a result
// is valid once it has passed through all three of them, in that order
// each stage holds its own valid bit and moves when the next one is free,
// so a stalled result only backs up full stages and bubbles close up
// reset clears the valid bits only; the datapath registers are not reset
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int unsigned CW = CompWidth,
  parameter int unsigned FB = FracBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k (CW bits each, a_r lowest)
  input  logic [8*CW-1:0]                s_axis_tdata,
  // req_type
  input  logic [OpWidth-1:0]             s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // res_r, res_i, res_j, res_k (CW bits each, res_r lowest), zero padded
  output logic [((4*CW+7)/8)*8-1:0]      m_axis_tdata,
  // overflow
  output logic                           m_axis_tuser
);

  localparam int unsigned AccW     = 2 * CW + 2;
  localparam int unsigned OutDataW = ((4 * CW + 7) / 8) * 8;

  // request unpacking
  logic signed [CW-1:0] req_a [4];
  logic signed [CW-1:0] req_b [4];

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      req_a[n] = s_axis_tdata[n*CW +: CW];
      req_b[n] = s_axis_tdata[(n+4)*CW +: CW];
    end
  end

  // product stage -> combine stage
  logic                   mul_valid, mul_ready;
  op_e                    mul_op;
  logic signed [CW-1:0]   mul_a [4];
  logic signed [CW-1:0]   mul_b [4];
  logic signed [2*CW-1:0] mul_prod [4][4];

  // combine stage -> saturate stage
  logic                   sum_valid, sum_ready;
  logic                   sum_scaled;
  logic signed [AccW-1:0] sum_acc [4];

  // result
  logic signed [CW-1:0]   res [4];
  logic                   res_ovf;

  qau_mul #(
    .CW (CW)
  ) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_a_i      (req_a),
    .in_b_i      (req_b),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .out_op_o    (mul_op),
    .out_a_o     (mul_a),
    .out_b_o     (mul_b),
    .out_prod_o  (mul_prod)
  );

  qau_sum #(
    .CW   (CW),
    .AccW (AccW)
  ) u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (mul_valid),
    .in_ready_o   (mul_ready),
    .in_op_i      (mul_op),
    .in_a_i       (mul_a),
    .in_b_i       (mul_b),
    .in_prod_i    (mul_prod),
    .out_valid_o  (sum_valid),
    .out_ready_i  (sum_ready),
    .out_scaled_o (sum_scaled),
    .out_acc_o    (sum_acc)
  );

  qau_sat #(
    .CW   (CW),
    .FB   (FB),
    .AccW (AccW)
  ) u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .in_scaled_i (sum_scaled),
    .in_acc_i    (sum_acc),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_ovf_o   (res_ovf)
  );

  // result packing, upper pad bits zero
  assign m_axis_tdata = OutDataW'({res[3], res[2], res[1], res[0]});
  assign m_axis_tuser = res_ovf;

endmodule

[sim/quat_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quat_result_checker
// watches both stream channels of the quaternion alu, predicts each result
// from the accepted request and compares it field by field, in order
// ----------------------------------------------------------------------------
module quat_result_checker import qau_pkg::*; (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k (a_r lowest)
  input  logic [8*CompWidth-1:0]              s_axis_tdata,
  // req_type
  input  logic [OpWidth-1:0]                  s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // res_r, res_i, res_j, res_k (res_r lowest), zero padded
  input  logic [((4*CompWidth+7)/8)*8-1:0]    m_axis_tdata,
  // overflow
  input  logic                                m_axis_tuser,
  output int                                  mismatch_count_o,
  output int                                  pending_o,
  output int                                  request_count_o,
  output int                                  result_count_o,
  output int                                  overflow_count_o
);

  typedef struct {
    logic [CompWidth-1:0] comp [4];
    logic                 ovf;
  } quat_result_t;

  quat_result_t expected_results [$];
  string        comp_name [4] = '{"res_r", "res_i", "res_j", "res_k"};

  int mismatches    = 0;
  int requests      = 0;
  int results       = 0;
  int overflow_hits = 0;

  assign mismatch_count_o = mismatches;
  assign request_count_o  = requests;
  assign result_count_o   = results;
  assign overflow_count_o = overflow_hits;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // products summed exactly, floor shift, then saturate each component
  function automatic quat_result_t predict_quat_result(input logic [OpWidth-1:0]     op,
                                                       input logic [8*CompWidth-1:0] operands);
    longint       a [4];
    longint       b [4];
    longint       wide [4];
    longint       comp_max;
    longint       comp_min;
    quat_result_t res;
    comp_max = (longint'(1) <<< (CompWidth - 1)) - 1;
    comp_min = -comp_max - 1;
    for (int n = 0; n < 4; n++) begin
      a[n]    = $signed(operands[n*CompWidth +: CompWidth]);
      b[n]    = $signed(operands[(n+4)*CompWidth +: CompWidth]);
      wide[n] = 0;
    end
    case (op)
      OP_ADD: begin
        for (int n = 0; n < 4; n++) wide[n] = a[n] + b[n];
      end
      OP_SUB: begin
        for (int n = 0; n < 4; n++) wide[n] = a[n] - b[n];
      end
      OP_MUL: begin
        wide[0] = (a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]) >>> FracBits;
        wide[1] = (a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]) >>> FracBits;
        wide[2] = (a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]) >>> FracBits;
        wide[3] = (a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]) >>> FracBits;
      end
      OP_NEG: begin
        for (int n = 0; n < 4; n++) wide[n] = -a[n];
      end
      OP_CONJ: begin
        wide[0] = a[0];
        for (int n = 1; n < 4; n++) wide[n] = -a[n];
      end
      OP_DOT: begin
        wide[0] = (a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]) >>> FracBits;
      end
      OP_SCALE: begin
        for (int n = 0; n < 4; n++) wide[n] = (b[0] * a[n]) >>> FracBits;
      end
      OP_ADD_SCALAR: begin
        wide[0] = a[0] + b[0];
        for (int n = 1; n < 4; n++) wide[n] = a[n];
      end
      OP_SCALAR_SUB: begin
        wide[0] = b[0] - a[0];
        for (int n = 1; n < 4; n++) wide[n] = -a[n];
      end
      default: begin
        // unused codes give an all-zero result
      end
    endcase
    res.ovf = 1'b0;
    for (int n = 0; n < 4; n++) begin
      if (wide[n] > comp_max) begin
        wide[n] = comp_max;
        res.ovf = 1'b1;
      end else if (wide[n] < comp_min) begin
        wide[n] = comp_min;
        res.ovf = 1'b1;
      end
      res.comp[n] = wide[n][CompWidth-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : watch_channels
    quat_result_t exp_res;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_quat_result(s_axis_tuser, s_axis_tdata));
        requests++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results++;
        if (m_axis_tuser === 1'b1) overflow_hits++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          exp_res = expected_results.pop_front();
          for (int n = 0; n < 4; n++) begin
            if (m_axis_tdata[n*CompWidth +: CompWidth] !== exp_res.comp[n]) begin
              report_mismatch($sformatf("result %0d %s: expected %0d, got %0d", results,
                              comp_name[n], $signed(exp_res.comp[n]),
                              $signed(m_axis_tdata[n*CompWidth +: CompWidth])));
            end
          end
          if (m_axis_tuser !== exp_res.ovf) begin
            report_mismatch($sformatf("result %0d overflow: expected %0b, got %0b", results,
                            exp_res.ovf, m_axis_tuser));
          end
        end
      end
    end
    pending_o <= expected_results.size();
  end

endmodule

[sim/quaternion_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_tb
// drives directed corner requests and then random requests through the
// quaternion alu under three idle patterns and two long output stalls;
// a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_tb import qau_pkg::*; ();

  localparam int CycleLimit     = 200000;
  localparam int RandomPerPhase = 245;
  localparam int LongStall      = 64;
  localparam int DrainCycles    = 12;

  localparam logic [CompWidth-1:0] QMax   = 16'h7FFF;
  localparam logic [CompWidth-1:0] QMin   = 16'h8000;
  localparam logic [CompWidth-1:0] One    = 16'h4000;
  localparam logic [CompWidth-1:0] NegOne = 16'hC000;
  localparam logic [CompWidth-1:0] Lsb    = 16'h0001;
  localparam logic [CompWidth-1:0] NegLsb = 16'hFFFF;

  // codes the block leaves unused
  localparam logic [OpWidth-1:0] OpUnusedFirst = 4'd9;
  localparam logic [OpWidth-1:0] OpUnusedLast  = 4'd15;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k (a_r lowest)
  logic [8*CompWidth-1:0]           s_axis_tdata  = '0;
  // req_type
  logic [OpWidth-1:0]               s_axis_tuser  = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // res_r, res_i, res_j, res_k (res_r lowest), zero padded
  logic [((4*CompWidth+7)/8)*8-1:0] m_axis_tdata;
  // overflow
  logic                             m_axis_tuser;

  int mismatch_count;
  int pending;
  int request_count;
  int result_count;
  int overflow_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int stalls_done    = 0;
  int cycle_count    = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  quaternion_arithmetic_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  quat_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .request_count_o  (request_count),
    .result_count_o   (result_count),
    .overflow_count_o (overflow_count)
  );

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("** quaternion_arithmetic_unit: FAILED **");
      $finish;
    end
  end

  // result side: random back-pressure, or a long hold when one is asked for
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_requests != stalls_done) begin
        m_axis_tready <= 1'b0;
        repeat (LongStall - 1) @(negedge clk_i);
        stalls_done++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one request: optional idle gap, then hold it until accepted;
  // returns at the falling edge after the accepting edge
  task automatic send_quat(input logic [OpWidth-1:0]   op,
                           input logic [CompWidth-1:0] ar, ai, aj, ak,
                           input logic [CompWidth-1:0] br, bi, bj, bk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {bk, bj, bi, br, ak, aj, ai, ar};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // operand mix weighted toward the extremes and values near one
  function automatic logic [CompWidth-1:0] rand_comp();
    case ($urandom_range(9))
      0:       return QMin;
      1:       return QMax;
      2:       return '0;
      3:       return One + CompWidth'($urandom_range(15)) - CompWidth'(8);
      4:       return NegOne + CompWidth'($urandom_range(15)) - CompWidth'(8);
      default: return CompWidth'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [OpWidth-1:0] op;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase 0 pacing: sender idles lightly, receiver heavily
    send_idle_pct = 20;
    recv_idle_pct = 74;

    // directed corners
    send_quat(OP_ADD, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax);
    send_quat(OP_ADD, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin);
    send_quat(OP_SUB, QMin, QMax, '0, NegLsb, QMax, QMin, Lsb, QMax);
    // unit products: 1*1, i*j, j*i
    send_quat(OP_MUL, One, '0, '0, '0, One, '0, '0, '0);
    send_quat(OP_MUL, '0, One, '0, '0, '0, '0, One, '0);
    send_quat(OP_MUL, '0, '0, One, '0, '0, One, '0, '0);
    send_quat(OP_MUL, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax);
    send_quat(OP_MUL, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin);
    // tiny negative product rounds toward minus infinity
    send_quat(OP_MUL, NegLsb, '0, '0, '0, Lsb, '0, '0, '0);
    // negating the most negative value saturates
    send_quat(OP_NEG, QMin, QMin, QMin, QMin, '0, '0, '0, '0);
    send_quat(OP_NEG, One, NegOne, Lsb, '0, QMax, QMin, QMax, QMin);
    send_quat(OP_CONJ, QMin, QMin, QMax, NegLsb, '0, '0, '0, '0);
    send_quat(OP_DOT, QMax, QMax, QMax, QMax, QMax, QMax, QMax, QMax);
    send_quat(OP_DOT, NegLsb, '0, '0, '0, Lsb, QMax, QMin, QMax);
    send_quat(OP_SCALE, QMin, QMin, QMin, QMin, QMin, '0, '0, '0);
    send_quat(OP_SCALE, Lsb, QMax, QMin, '0, NegLsb, QMax, QMax, QMax);
    send_quat(OP_SCALE, QMax, QMin, NegOne, Lsb, One, '0, '0, '0);
    send_quat(OP_ADD_SCALAR, QMax, QMin, QMin, QMin, QMax, QMax, QMax, QMax);
    // scalar minus saturates the real and i components
    send_quat(OP_SCALAR_SUB, QMax, QMin, QMax, '0, QMin, '0, '0, '0);
    send_quat(OP_SCALAR_SUB, One, NegOne, Lsb, NegLsb, One, QMin, QMin, QMin);
    send_quat(OpUnusedFirst, QMax, QMin, One, NegOne, QMax, QMin, One, NegOne);
    send_quat(OpUnusedLast, QMin, QMin, QMin, QMin, QMin, QMin, QMin, QMin);

    // random requests under three pacing patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int item = 0; item < RandomPerPhase; item++) begin
        // long output hold while requests keep coming, so the pipe backs up
        if (phase > 0 && item == 60) stall_requests++;
        if ($urandom_range(19) == 0) op = OpWidth'($urandom_range(15, 9));
        else op = OpWidth'($urandom_range(8));
        send_quat(op, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain: wait for every outstanding result, then watch for strays
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests (all nine operations and unused codes, extremes)",
             request_count);
    $display("checked %0d results, %0d with overflow, %0d mismatches",
             result_count, overflow_count, mismatch_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("** quaternion_arithmetic_unit: PASSED **");
    end else begin
      $display("** quaternion_arithmetic_unit: FAILED **");
    end
    $finish;
  end

endmodule
